### sv/htc_pkg.sv
// htc_pkg: shared types and constants for the homogeneous triangle clipper.
// No dependencies; imported by htc_front, htc_back and the top level.
package htc_pkg;

   localparam int RESULT_LIMIT = 16;
   localparam int NUM_COORDS   = 4;
   localparam int NUM_VERTS_IN = 3;
   localparam int MIN_W_BITS   = 17;
   localparam logic [MIN_W_BITS-1:0] MIN_W_RESET = 17'd1;

   // Clip planes in the order they are applied.
   typedef enum logic [2:0] {
      PLANE_NEAR_W,
      PLANE_POS_X,
      PLANE_NEG_X,
      PLANE_POS_Y,
      PLANE_NEG_Y,
      PLANE_POS_Z,
      PLANE_NEG_Z
   } plane_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PLANE_START,
      ST_PREV,
      ST_EVAL,
      ST_DIST,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_PUSH_NV,
      ST_PUSH_CV,
      ST_NEXT,
      ST_FINISH,
      ST_REJECT,
      ST_EMIT_START,
      ST_EMIT
   } back_state_type;

   // Head of the triangle queue as seen by the back end.
   typedef struct packed {
      logic valid;
      logic visible;
   } tri_status_type;

endpackage

### sv/htc_ram.sv
// htc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module htc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/htc_front.sv
// htc_front: accepts triangles, flags trivially visible ones, and holds them
// in a two-entry queue for the back end. Depends on htc_pkg.
module htc_front #(
   parameter int COORD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [12*COORD_BITS-1:0]            tri_in,
   input  logic                                pop,
   output htc_pkg::tri_status_type             status,
   output logic [12*COORD_BITS-1:0]            tri_out
);
   import htc_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int TW = 12 * COORD_BITS;

   logic [TW-1:0] tri_ff [2];
   logic          vis_ff [2];
   logic          wptr_ff, wptr_in;
   logic          rptr_ff, rptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push;
   logic          visible;

   // |x|,|y|,|z| <= w for all three vertices
   always_comb begin
      logic signed [C+1:0] w;
      logic signed [C+1:0] a;
      visible = 1'b1;
      for (int v = 0; v < NUM_VERTS_IN; v++) begin
         w = {{2{tri_in[(v*4+3)*C+C-1]}}, tri_in[(v*4+3)*C +: C]};
         for (int c = 0; c < 3; c++) begin
            a = {{2{tri_in[(v*4+c)*C+C-1]}}, tri_in[(v*4+c)*C +: C]};
            if (a > w || a < -w) begin
               visible = 1'b0;
            end
         end
      end
   end

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         tri_ff[wptr_ff] <= tri_in;
         vis_ff[wptr_ff] <= visible;
      end
   end

   assign status.valid   = (cnt_ff != 2'd0);
   assign status.visible = vis_ff[rptr_ff];
   assign tri_out        = tri_ff[rptr_ff];

endmodule

### sv/htc_div.sv
// htc_div: restoring divider for the edge ratio, one quotient bit a cycle.
// Gives floor(num * 2^FRAC_BITS / den), or 2^FRAC_BITS when num >= den.
module htc_div #(
   parameter int NUM_BITS  = 35,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [NUM_BITS-1:0]  num,
   input  logic [NUM_BITS:0]    den,
   output logic                 done,
   output logic [FRAC_BITS:0]   quot
);

   localparam int NB = NUM_BITS;
   localparam int F  = FRAC_BITS;
   localparam int KW = $clog2(F + 1);

   logic              run_ff;
   logic              done_ff;
   logic [KW-1:0]     cnt_ff;
   logic [NB+1:0]     rem_ff;
   logic [NB:0]       den_ff;
   logic [F:0]        q_ff;
   logic [NB+1:0]     rem2;

   assign rem2 = {rem_ff[NB:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            if ({1'b0, num} >= den) begin
               done_ff <= 1'b1;
            end else begin
               run_ff <= 1'b1;
            end
         end else if (run_ff && cnt_ff == KW'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= {2'b00, num};
         den_ff <= den;
         cnt_ff <= KW'(F);
         if ({1'b0, num} >= den) begin
            q_ff <= {1'b1, {F{1'b0}}};
         end else begin
            q_ff <= '0;
         end
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - KW'(1);
         if (rem2 >= {1'b0, den_ff}) begin
            rem_ff <= rem2 - {1'b0, den_ff};
            q_ff   <= {q_ff[F-1:0], 1'b1};
         end else begin
            rem_ff <= rem2;
            q_ff   <= {q_ff[F-1:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### sv/htc_back.sv
// htc_back: sequencer that clips the queued triangle plane by plane through
// two ping-pong vertex RAMs and emits the polygon. Uses htc_pkg, htc_ram, htc_div.
module htc_back #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 32,
   parameter int FRAC_BITS    = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  htc_pkg::tri_status_type         status,
   input  logic [12*COORD_BITS-1:0]        tri_in,
   output logic                            pop,
   input  logic [htc_pkg::MIN_W_BITS-1:0]  min_w,
   output logic                            rsp_strobe,
   output logic [4*COORD_BITS-1:0]         rsp_vertex,
   output logic                            rsp_last_vertex,
   output logic                            rsp_rejected,
   output logic                            rsp_overflow
);
   import htc_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int VW   = 4 * COORD_BITS;
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int CW   = $clog2(MAX_VERTICES + 1);
   localparam int DW   = COORD_BITS + 3;
   localparam int PW   = COORD_BITS + FRAC_BITS + 2;
   localparam int KLIM = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;

   back_state_type state_ff, state_in;
   plane_type      plane_ff, plane_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           dropped_ff, dropped_in;
   logic           src_sel_ff, src_sel_in;
   logic [1:0]     coord_ff, coord_in;
   logic           cin_ff;
   logic [VW-1:0]  prev_ff, curr_ff, nv_ff;
   logic [F:0]     ratio_ff;
   logic [PW-1:0]  prod_ff;
   logic           neg_ff;
   logic           strobe_ff;
   logic [VW-1:0]  vert_ff;
   logic           last_ff, rej_ff, ovf_ff;

   logic          we_a, we_b, wr;
   logic [AW-1:0] waddr, raddr;
   logic [VW-1:0] wdata, rdata_a, rdata_b, rdata;

   logic                 div_go, div_done;
   logic [DW-1:0]        mag_p, mag_c;
   logic [DW:0]          den;
   logic [F:0]           quot;
   logic signed [DW-1:0] dist_p, dist_c;
   logic [CW-1:0]        klim_n;

   function automatic logic signed [DW-1:0] dist_f(input logic [VW-1:0] v,
                                                   input plane_type p,
                                                   input logic [MIN_W_BITS-1:0] mw);
      logic signed [DW-1:0] x, y, z, w, m;
      x = {{3{v[C-1]}},     v[C-1:0]};
      y = {{3{v[2*C-1]}},   v[C +: C]};
      z = {{3{v[3*C-1]}},   v[2*C +: C]};
      w = {{3{v[4*C-1]}},   v[3*C +: C]};
      m = {{(DW-MIN_W_BITS){1'b0}}, mw};
      case (p)
         PLANE_NEAR_W: dist_f = w - m;
         PLANE_POS_X:  dist_f = w - x;
         PLANE_NEG_X:  dist_f = w + x;
         PLANE_POS_Y:  dist_f = w - y;
         PLANE_NEG_Y:  dist_f = w + y;
         PLANE_POS_Z:  dist_f = w - z;
         default:      dist_f = w + z;
      endcase
   endfunction

   htc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_buf_a (
      .clock (clock), .we (we_a), .waddr (waddr), .wdata (wdata),
      .raddr (raddr), .rdata (rdata_a)
   );

   htc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_buf_b (
      .clock (clock), .we (we_b), .waddr (waddr), .wdata (wdata),
      .raddr (raddr), .rdata (rdata_b)
   );

   htc_div #(.NUM_BITS(DW), .FRAC_BITS(F)) u_div (
      .clock (clock), .reset (reset), .go (div_go), .num (mag_p), .den (den),
      .done (div_done), .quot (quot)
   );

   assign rdata = src_sel_ff ? rdata_b : rdata_a;

   // plane distances of the current edge
   always_comb begin
      dist_p = dist_f(prev_ff, plane_ff, min_w);
      dist_c = dist_f(curr_ff, plane_ff, min_w);
      mag_p  = dist_p[DW-1] ? DW'(-dist_p) : DW'(dist_p);
      mag_c  = dist_c[DW-1] ? DW'(-dist_c) : DW'(dist_c);
      den    = {1'b0, mag_p} + {1'b0, mag_c};
      klim_n = (n_ff > CW'(KLIM)) ? CW'(KLIM) : n_ff;
   end

   // next state and datapath control
   always_comb begin
      state_in   = state_ff;
      plane_in   = plane_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      cnt_in     = cnt_ff;
      dropped_in = dropped_ff;
      src_sel_in = src_sel_ff;
      coord_in   = coord_ff;
      pop        = 1'b0;
      div_go     = 1'b0;
      wr         = 1'b0;
      we_a       = 1'b0;
      waddr      = cnt_ff[AW-1:0];
      wdata      = nv_ff;
      raddr      = idx_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (status.valid) begin
               state_in   = ST_LOAD;
               idx_in     = '0;
               n_in       = CW'(NUM_VERTS_IN);
               dropped_in = 1'b0;
               src_sel_in = 1'b0;
               plane_in   = PLANE_NEAR_W;
            end
         end
         ST_LOAD: begin
            we_a   = 1'b1;
            waddr  = idx_ff[AW-1:0];
            wdata  = tri_in[idx_ff*VW +: VW];
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(NUM_VERTS_IN - 1)) begin
               pop      = 1'b1;
               state_in = status.visible ? ST_EMIT_START : ST_PLANE_START;
            end
         end
         ST_PLANE_START: begin
            raddr    = AW'(n_ff - CW'(1));
            cnt_in   = '0;
            state_in = ST_PREV;
         end
         ST_PREV: begin
            raddr    = '0;
            idx_in   = '0;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DIST;
         end
         ST_DIST: begin
            if (dist_p[DW-1] != dist_c[DW-1]) begin
               div_go   = 1'b1;
               state_in = ST_DIV;
            end else if (!dist_c[DW-1]) begin
               state_in = ST_PUSH_CV;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DIV: begin
            coord_in = '0;
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            coord_in = coord_ff + 2'd1;
            state_in = (coord_ff == 2'd3) ? ST_PUSH_NV : ST_MUL;
         end
         ST_PUSH_NV: begin
            wr       = 1'b1;
            state_in = cin_ff ? ST_PUSH_CV : ST_NEXT;
         end
         ST_PUSH_CV: begin
            wr       = 1'b1;
            wdata    = curr_ff;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            raddr = AW'(idx_ff + CW'(1));
            if (idx_ff == n_ff - CW'(1)) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_EVAL;
            end
         end
         ST_FINISH: begin
            n_in       = cnt_ff;
            src_sel_in = !src_sel_ff;
            if (cnt_ff < CW'(3)) begin
               state_in = ST_REJECT;
            end else if (plane_ff == PLANE_NEG_Z) begin
               state_in = ST_EMIT_START;
            end else begin
               plane_in = plane_type'(plane_ff + 3'd1);
               state_in = ST_PLANE_START;
            end
         end
         ST_REJECT: begin
            state_in = ST_IDLE;
         end
         ST_EMIT_START: begin
            raddr    = '0;
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            raddr  = AW'(idx_ff + CW'(1));
            idx_in = idx_ff + CW'(1);
            if (idx_ff == klim_n - CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // pushes beyond the buffer are dropped and flagged
      if (wr) begin
         if (cnt_ff < CW'(MAX_VERTICES)) begin
            cnt_in = cnt_ff + CW'(1);
         end else begin
            wr         = 1'b0;
            dropped_in = 1'b1;
         end
      end
      we_b = wr && !src_sel_ff;
      if (wr && src_sel_ff) begin
         we_a = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         plane_ff   <= PLANE_NEAR_W;
         idx_ff     <= '0;
         n_ff       <= '0;
         cnt_ff     <= '0;
         dropped_ff <= 1'b0;
         src_sel_ff <= 1'b0;
         coord_ff   <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         plane_ff   <= plane_in;
         idx_ff     <= idx_in;
         n_ff       <= n_in;
         cnt_ff     <= cnt_in;
         dropped_ff <= dropped_in;
         src_sel_ff <= src_sel_in;
         coord_ff   <= coord_in;
         strobe_ff  <= (state_ff == ST_REJECT) || (state_ff == ST_EMIT);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      logic signed [C:0]   a, b, delta;
      logic [C:0]          m;
      logic signed [C+1:0] p, res;
      a     = {prev_ff[coord_ff*C + C - 1], prev_ff[coord_ff*C +: C]};
      b     = {curr_ff[coord_ff*C + C - 1], curr_ff[coord_ff*C +: C]};
      delta = b - a;
      m     = delta[C] ? (C+1)'(-delta) : (C+1)'(delta);
      p     = prod_ff[PW-1:F];
      res   = neg_ff ? ({a[C], a} - p) : ({a[C], a} + p);
      case (state_ff)
         ST_PREV:  prev_ff <= rdata;
         ST_EVAL:  curr_ff <= rdata;
         ST_DIST:  cin_ff  <= !dist_c[DW-1];
         ST_DIV:   ratio_ff <= quot;
         ST_MUL: begin
            prod_ff <= PW'(m) * PW'(ratio_ff);
            neg_ff  <= delta[C];
         end
         ST_ADD:   nv_ff[coord_ff*C +: C] <= res[C-1:0];
         ST_NEXT:  prev_ff <= curr_ff;
         default: begin
         end
      endcase
      last_ff <= (state_ff == ST_REJECT) || (idx_ff == klim_n - CW'(1));
      rej_ff  <= (state_ff == ST_REJECT);
      ovf_ff  <= dropped_ff || (n_ff > CW'(KLIM));
      vert_ff <= (state_ff == ST_REJECT) ? '0 : rdata;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_vertex      = vert_ff;
   assign rsp_last_vertex = last_ff;
   assign rsp_rejected    = rej_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

### sv/homogeneous_triangle_clipper.sv
// homogeneous_triangle_clipper: seven-plane clip of one triangle into a vertex run.
// A triangle that is fully inside is emitted directly; a clipped one is cut plane by
// plane, each crossing edge set by the one-bit-a-cycle ratio divider and a multiply-add per coordinate.
// Throughput: one triangle at a time in the back end; two more may wait in the queue.
// Reset (synchronous, active high) empties the queue and sets min_w to 1.
module homogeneous_triangle_clipper #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 32,
   parameter int FRAC_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // triangle input
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_BITS-1:0]         req_v0_x,
   input  logic signed [COORD_BITS-1:0]         req_v0_y,
   input  logic signed [COORD_BITS-1:0]         req_v0_z,
   input  logic signed [COORD_BITS-1:0]         req_v0_w,
   input  logic signed [COORD_BITS-1:0]         req_v1_x,
   input  logic signed [COORD_BITS-1:0]         req_v1_y,
   input  logic signed [COORD_BITS-1:0]         req_v1_z,
   input  logic signed [COORD_BITS-1:0]         req_v1_w,
   input  logic signed [COORD_BITS-1:0]         req_v2_x,
   input  logic signed [COORD_BITS-1:0]         req_v2_y,
   input  logic signed [COORD_BITS-1:0]         req_v2_z,
   input  logic signed [COORD_BITS-1:0]         req_v2_w,
   // vertex output, one beat per strobe, no back-pressure
   output logic                                 rsp_strobe,
   output logic signed [COORD_BITS-1:0]         rsp_out_x,
   output logic signed [COORD_BITS-1:0]         rsp_out_y,
   output logic signed [COORD_BITS-1:0]         rsp_out_z,
   output logic signed [COORD_BITS-1:0]         rsp_out_w,
   output logic                                 rsp_last_vertex,
   output logic                                 rsp_rejected,
   output logic                                 rsp_overflow,
   // near-w epsilon register
   input  logic                                 csr_we,
   input  logic [htc_pkg::MIN_W_BITS-1:0]       csr_min_w
);
   import htc_pkg::*;

   localparam int C = COORD_BITS;

   logic [MIN_W_BITS-1:0] min_w_ff;
   logic [12*C-1:0]       tri_in, tri_q;
   logic [4*C-1:0]        vertex;
   logic                  pop;
   tri_status_type        status;

   // min_w is to be written only while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         min_w_ff <= MIN_W_RESET;
      end else if (csr_we) begin
         min_w_ff <= csr_min_w;
      end
   end

   // vertex i occupies bits [i*4C +: 4C], coordinates x,y,z,w from the bottom
   assign tri_in = {req_v2_w, req_v2_z, req_v2_y, req_v2_x,
                    req_v1_w, req_v1_z, req_v1_y, req_v1_x,
                    req_v0_w, req_v0_z, req_v0_y, req_v0_x};

   // front: accept, trivial-accept test, two-deep queue
   htc_front #(.COORD_BITS(C)) u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .tri_in  (tri_in),
      .pop     (pop),
      .status  (status),
      .tri_out (tri_q)
   );

   // back: plane-by-plane clip and vertex emit
   htc_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (C),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .status          (status),
      .tri_in          (tri_q),
      .pop             (pop),
      .min_w           (min_w_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_vertex      (vertex),
      .rsp_last_vertex (rsp_last_vertex),
      .rsp_rejected    (rsp_rejected),
      .rsp_overflow    (rsp_overflow)
   );

   assign rsp_out_x = vertex[C-1:0];
   assign rsp_out_y = vertex[2*C-1:C];
   assign rsp_out_z = vertex[3*C-1:2*C];
   assign rsp_out_w = vertex[4*C-1:3*C];

   // a rejected beat is a lone, zeroed, final beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_rejected |-> rsp_last_vertex && rsp_out_w == 0 && rsp_out_x == 0)
      else $error("rejected beat not final or not zeroed");

   // polygon vertices stream without gaps until the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_vertex |=> rsp_strobe)
      else $error("gap inside a vertex run");

   // the back end leaves a gap between triangles: no strobe directly follows a last beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_vertex |=> !rsp_strobe)
      else $error("vertex run did not end after last beat");

   // overflow is constant across one triangle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_vertex |=> rsp_overflow == $past(rsp_overflow))
      else $error("overflow flag changed inside a vertex run");

endmodule

### tb/tb.sv
// tb: self-checking bench for homogeneous_triangle_clipper, seven-plane clip.
// Depends on htc_pkg and the clipper RTL; an in-bench clip predictor feeds a scoreboard.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import htc_pkg::*;

   localparam int MAXV = 16;
   localparam int FRAC = 16;

   typedef struct {
      logic signed [31:0] x, y, z, w;
      logic               last, rej, ovf;
   } vert_beat_type;

   typedef logic signed [63:0] coord4_type [4];

   // ---------------------------------------------------------------------
   // scoreboard: expected vertex beats in polygon order
   // ---------------------------------------------------------------------
   class vertex_board;
      vert_beat_type pending[$];
      int            errors;

      function void note_triangle(vert_beat_type beats[$]);
         foreach (beats[i]) pending.push_back(beats[i]);
      endfunction

      function void check_beat(vert_beat_type got);
         vert_beat_type want;
         if (pending.size() == 0) begin
            report_mismatch("vertex beat with nothing expected");
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x) report_mismatch($sformatf("x %h want %h", got.x, want.x));
         if (got.y !== want.y) report_mismatch($sformatf("y %h want %h", got.y, want.y));
         if (got.z !== want.z) report_mismatch($sformatf("z %h want %h", got.z, want.z));
         if (got.w !== want.w) report_mismatch($sformatf("w %h want %h", got.w, want.w));
         if (got.last !== want.last)
            report_mismatch($sformatf("last_vertex %b want %b", got.last, want.last));
         if (got.rej !== want.rej)
            report_mismatch($sformatf("rejected %b want %b", got.rej, want.rej));
         if (got.ovf !== want.ovf)
            report_mismatch($sformatf("overflow %b want %b", got.ovf, want.ovf));
      endfunction

      function void report_mismatch(string msg);
         errors++;
         $display("MISMATCH @%0t: %s", $time, msg);
      endfunction
   endclass

   vertex_board board = new();

   // ---------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------
   logic clock = 0, reset = 1;
   logic start = 0, busy;
   logic signed [31:0] tri_in [12];
   logic rsp_strobe, rsp_last_vertex, rsp_rejected, rsp_overflow;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic csr_we = 0;
   logic [MIN_W_BITS-1:0] csr_min_w = '0;

   initial foreach (tri_in[i]) tri_in[i] = '0;

   homogeneous_triangle_clipper dut (
      .clock, .reset, .start, .busy,
      .req_v0_x(tri_in[0]), .req_v0_y(tri_in[1]), .req_v0_z(tri_in[2]), .req_v0_w(tri_in[3]),
      .req_v1_x(tri_in[4]), .req_v1_y(tri_in[5]), .req_v1_z(tri_in[6]), .req_v1_w(tri_in[7]),
      .req_v2_x(tri_in[8]), .req_v2_y(tri_in[9]), .req_v2_z(tri_in[10]),
      .req_v2_w(tri_in[11]),
      .rsp_strobe, .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_out_w,
      .rsp_last_vertex, .rsp_rejected, .rsp_overflow,
      .csr_we, .csr_min_w
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // ---------------------------------------------------------------------
   // predictor: our own min_w copy and fixed-point Sutherland-Hodgman clip
   // ---------------------------------------------------------------------
   logic [MIN_W_BITS-1:0] near_w_eps = MIN_W_RESET;
   bit                    lost_verts;

   function automatic logic signed [63:0] plane_distance(coord4_type v, plane_type p);
      case (p)
         PLANE_NEAR_W: return v[3] - $signed({47'd0, near_w_eps});
         PLANE_POS_X:  return v[3] - v[0];
         PLANE_NEG_X:  return v[3] + v[0];
         PLANE_POS_Y:  return v[3] - v[1];
         PLANE_NEG_Y:  return v[3] + v[1];
         PLANE_POS_Z:  return v[3] - v[2];
         default:      return v[3] + v[2];
      endcase
   endfunction

   function automatic logic [63:0] magnitude(logic signed [63:0] a);
      return a < 0 ? -a : a;
   endfunction

   // restoring divide, Q1.16, saturates at 1.0
   function automatic logic [63:0] crossing_ratio(logic [63:0] num, logic [63:0] den);
      logic [63:0] q, r;
      q = 0;
      r = num;
      if (num >= den) return 64'd1 << FRAC;
      for (int i = 0; i < FRAC; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic signed [63:0] interp(logic signed [63:0] a, logic signed [63:0] b,
                                                 logic [63:0] r);
      logic signed [63:0] delta;
      logic [63:0] m, p;
      delta = b - a;
      m = magnitude(delta);
      p = (m >> FRAC) * r + (((m & 64'hFFFF) * r) >> FRAC);
      return delta < 0 ? a - $signed(p) : a + $signed(p);
   endfunction

   function automatic void append_vert(ref coord4_type poly[$], input coord4_type v);
      if (poly.size() < MAXV) poly.push_back(v);
      else lost_verts = 1;
   endfunction

   function automatic void clip_to_plane(input coord4_type src[$], ref coord4_type dst[$],
                                         input plane_type p);
      coord4_type pv, cv, nv;
      logic signed [63:0] dp, dc;
      logic [63:0] r;
      int n;
      n = src.size();
      dst = {};
      for (int i = 0; i < n; i++) begin
         pv = src[i == 0 ? n - 1 : i - 1];
         cv = src[i];
         dp = plane_distance(pv, p);
         dc = plane_distance(cv, p);
         if ((dp >= 0) != (dc >= 0)) begin
            r = crossing_ratio(magnitude(dp), magnitude(dp) + magnitude(dc));
            for (int c = 0; c < 4; c++) nv[c] = interp(pv[c], cv[c], r);
            append_vert(dst, nv);
         end
         if (dc >= 0) append_vert(dst, cv);
      end
   endfunction

   function automatic void predict_clip(output vert_beat_type beats[$]);
      coord4_type poly[$], nxt[$], v;
      bit all_in;
      vert_beat_type b;
      int k;
      beats = {};
      lost_verts = 0;
      all_in = 1;
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 4; c++) v[c] = tri_in[i*4+c];
         for (int c = 0; c < 3; c++)
            if (v[c] > v[3] || v[c] < -v[3]) all_in = 0;
         poly.push_back(v);
      end
      if (!all_in)
         for (int p = 0; p < 7; p++) begin
            clip_to_plane(poly, nxt, plane_type'(p));
            poly = nxt;
            if (poly.size() < 3) begin
               b = '{x:0, y:0, z:0, w:0, last:1, rej:1, ovf:lost_verts};
               beats.push_back(b);
               return;
            end
         end
      k = poly.size();
      if (k > RESULT_LIMIT) begin
         k = RESULT_LIMIT;
         lost_verts = 1;
      end
      for (int i = 0; i < k; i++) begin
         b.x = poly[i][0][31:0]; b.y = poly[i][1][31:0];
         b.z = poly[i][2][31:0]; b.w = poly[i][3][31:0];
         b.last = (i == k - 1); b.rej = 0; b.ovf = lost_verts;
         beats.push_back(b);
      end
   endfunction

   // ---------------------------------------------------------------------
   // response monitor: no back-pressure, every strobe is a beat
   // ---------------------------------------------------------------------
   always @(posedge clock)
      if (!reset && rsp_strobe === 1'b1) begin
         vert_beat_type got;
         got = '{x:rsp_out_x, y:rsp_out_y, z:rsp_out_z, w:rsp_out_w,
                 last:rsp_last_vertex, rej:rsp_rejected, ovf:rsp_overflow};
         board.check_beat(got);
      end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   bit quiet_tail;
   bit start_held;
   logic signed [31:0] stage [12];

   // start stays high into the next triangle unless a gap is taken
   task automatic idle_gap();
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         start <= 0;
         start_held = 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // presents one triangle and holds start until the beat is taken
   task automatic send_triangle();
      vert_beat_type beats[$];
      foreach (stage[i]) tri_in[i] <= stage[i];
      start <= 1;
      start_held = 1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      // the edge just sampled took the beat; predict from what was driven
      predict_clip(beats);
      board.note_triangle(beats);
      idle_gap();
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      if (start_held) begin
         start <= 0;
         start_held = 0;
      end
      // every triangle gives at least one beat, so an empty board means idle
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic write_min_w(logic [MIN_W_BITS-1:0] val);
      drain();
      csr_we <= 1;
      csr_min_w <= val;
      @(posedge clock);
      near_w_eps = val;
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $signed($urandom());
         1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   task automatic set_vertex(int i, logic signed [31:0] x, y, z, w);
      stage[i*4] = x; stage[i*4+1] = y; stage[i*4+2] = z; stage[i*4+3] = w;
   endtask

   task automatic random_triangle();
      int mode;
      mode = $urandom_range(0, 9);
      foreach (stage[i]) stage[i] = rand_coord(mode == 0 ? 0 : (mode < 5 ? 1 : 2));
      // bias w positive most of the time so clipping produces real polygons
      if (mode != 0)
         for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 4) != 0) stage[i*4+3] = $urandom_range(1, 32'h0030_0000);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   localparam logic signed [31:0] ONE = 32'sh0001_0000;
   localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: fully inside
      set_vertex(0, 0, 0, 0, ONE); set_vertex(1, ONE, 0, 0, ONE);
      set_vertex(2, 0, -ONE, ONE, ONE);
      send_triangle();
      // extremes of the coordinate range, all bits toggled
      set_vertex(0, SMAX, SMIN, SMAX, SMAX); set_vertex(1, SMIN, SMAX, SMIN, SMIN);
      set_vertex(2, -1, 0, -1, SMAX);
      send_triangle();
      set_vertex(0, SMAX, SMAX, SMAX, SMAX); set_vertex(1, SMIN+1, 0, 0, SMAX);
      set_vertex(2, 0, SMIN+1, SMIN+1, SMAX);
      send_triangle();
      // nonpositive w everywhere: rejected
      set_vertex(0, 0, 0, 0, 0); set_vertex(1, 0, 0, 0, -ONE);
      set_vertex(2, ONE, ONE, ONE, SMIN);
      send_triangle();
      // behind near plane on one vertex
      set_vertex(0, 0, 0, 0, ONE); set_vertex(1, ONE/2, 0, 0, ONE);
      set_vertex(2, 0, 0, 0, -ONE);
      send_triangle();
      // each side plane crossed
      for (int p = 0; p < 6; p++) begin
         set_vertex(0, 0, 0, 0, ONE); set_vertex(1, ONE/2, ONE/2, 0, ONE);
         set_vertex(2, 0, 0, 0, ONE);
         stage[8 + p/2] = (p % 2) ? -3*ONE : 3*ONE;
         send_triangle();
      end
      // big triangle crossing every side: many vertices, overflow region
      set_vertex(0, -40*ONE, -40*ONE, 30*ONE, ONE); set_vertex(1, 80*ONE, -5*ONE, -30*ONE, ONE);
      set_vertex(2, -10*ONE, 90*ONE, 5*ONE, ONE);
      send_triangle();
      set_vertex(0, -9*ONE, 7*ONE, -9*ONE, ONE); set_vertex(1, 9*ONE, 9*ONE, 9*ONE, 2*ONE);
      set_vertex(2, 0, -9*ONE, 8*ONE, ONE/2);
      send_triangle();
      // entirely outside one plane: rejected
      set_vertex(0, 5*ONE, 0, 0, ONE); set_vertex(1, 6*ONE, 0, 0, ONE);
      set_vertex(2, 7*ONE, ONE, 0, ONE);
      send_triangle();
      // w exactly on the near epsilon
      set_vertex(0, 0, 0, 0, 1); set_vertex(1, 2, 0, 0, 1); set_vertex(2, 0, 3, 0, ONE);
      send_triangle();

      // random phases across register settings, extremes included
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_min_w(MIN_W_RESET);
            1: write_min_w(17'd0);
            2: write_min_w(17'h10000);
            3: write_min_w(17'h1FFFF);
            default: write_min_w($urandom_range(0, 17'h10000));
         endcase
         for (int n = 0; n < 80; n++) begin
            quiet_tail = (phase == 4 && n >= 60);
            random_triangle();
            send_triangle();
         end
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("** homogeneous_triangle_clipper: PASSED **");
      else
         $display("** homogeneous_triangle_clipper: FAILED **");
      $finish;
   end

   initial begin
      #200ms;
      $display("** homogeneous_triangle_clipper: FAILED **");
      $finish;
   end
endmodule
